@@ design/pfb_pkg.sv @@
// Shared types and request codes for the page framebuffer draw engine.
`timescale 1ns / 1ps

package pfb_pkg;

  // Request codes as carried on req_type and request_echo.
  localparam logic [2:0] REQ_CLEAR     = 3'd0;
  localparam logic [2:0] REQ_SET_PIXEL = 3'd1;
  localparam logic [2:0] REQ_FILL      = 3'd2;
  localparam logic [2:0] REQ_OUTLINE   = 3'd3;
  localparam logic [2:0] REQ_READ_BYTE = 3'd4;

  // Signed coordinate wide enough for edge sums of 11-bit fields.
  typedef logic signed [12:0] coord_t;

  typedef enum logic [2:0] {
    ST_WIPE,
    ST_IDLE,
    ST_CLEAR,
    ST_SETUP,
    ST_READ,
    ST_WRITE,
    ST_FETCH
  } state_t;

endpackage

@@ design/pfb_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module pfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/pfb_clip.sv @@
// Rectangle clipper: clamps one rectangle to the screen and flags empty ones.
`timescale 1ns / 1ps

module pfb_clip #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64,
  parameter int COL_W         = 7,
  parameter int ROW_W         = 6
) (
  input  pfb_pkg::coord_t   x,
  input  pfb_pkg::coord_t   y,
  input  pfb_pkg::coord_t   w,
  input  pfb_pkg::coord_t   h,
  output logic              empty,
  output logic [COL_W-1:0]  col_first,
  output logic [COL_W-1:0]  col_last,
  output logic [ROW_W-1:0]  row_first,
  output logic [ROW_W-1:0]  row_last
);

  import pfb_pkg::*;

  localparam coord_t WIDTH_C  = coord_t'(SCREEN_WIDTH);
  localparam coord_t HEIGHT_C = coord_t'(SCREEN_HEIGHT);

  coord_t x_end, y_end;
  coord_t x_lo, y_lo, x_hi, y_hi;

  always_comb begin
    // exclusive right and bottom edges
    x_end = x + w;
    y_end = y + h;
    empty = (w <= 0) || (h <= 0) || (x >= WIDTH_C) || (y >= HEIGHT_C) ||
            (x_end <= 0) || (y_end <= 0);
    x_lo  = (x < 0) ? '0 : x;
    y_lo  = (y < 0) ? '0 : y;
    x_hi  = ((x_end > WIDTH_C) ? WIDTH_C : x_end) - coord_t'(1);
    y_hi  = ((y_end > HEIGHT_C) ? HEIGHT_C : y_end) - coord_t'(1);
    col_first = x_lo[COL_W-1:0];
    col_last  = x_hi[COL_W-1:0];
    row_first = y_lo[ROW_W-1:0];
    row_last  = y_hi[ROW_W-1:0];
  end

endmodule

@@ design/page_framebuffer_draw_engine_unit.sv @@
// Top level: page-organized monochrome frame store with its drawing sequencer.
`timescale 1ns / 1ps

// Channel   Ports                                            Handshake
// --------  -----------------------------------------------  ------------------------------
// request   req_type pos_x pos_y rect_width rect_height      taken when start & !busy
//           pixel_on byte_address
// result    read_data request_echo                           one word per request, on done
//
// done shows in the cycle after a request completes. Clear: every byte written to zero,
// one byte per cycle. Set pixel, fill and outline: per rectangle (one, or four for an
// outline at least two wide and two high) a setup step, then for each touched byte a read
// and a merged write back. Read byte: answered from the fetch state. Unknown codes:
// answered at once from idle, busy stays low. Reset: rst sweeps the store to zero with
// busy high; no request is taken. done is a one-cycle strobe the receiver cannot stall;
// the next request may be taken in the cycle it shows.
module page_framebuffer_draw_engine_unit #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         req_type,
  input  logic signed [10:0] pos_x,
  input  logic signed [10:0] pos_y,
  input  logic signed [10:0] rect_width,
  input  logic signed [10:0] rect_height,
  input  logic               pixel_on,
  input  logic [9:0]         byte_address,
  output logic               done,
  output logic [7:0]         read_data,
  output logic [2:0]         request_echo
);

  import pfb_pkg::*;

  localparam int PAGE_COUNT  = (SCREEN_HEIGHT + 7) / 8;
  localparam int STORE_BYTES = SCREEN_WIDTH * PAGE_COUNT;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int COL_W       = $clog2(SCREEN_WIDTH);
  // at least one page bit above the three bit-in-byte bits
  localparam int ROW_W       = ($clog2(SCREEN_HEIGHT) > 4) ? $clog2(SCREEN_HEIGHT) : 4;
  localparam int PAGE_W      = ROW_W - 3;

  state_t state, state_next;

  // latched request
  logic [2:0]         req;
  logic signed [10:0] rx, ry, rw, rh;
  logic               ron;
  logic               rd_ok;

  // rectangle sequencing: an outline walks its top, bottom, left and right edge rectangles unless it is thin
  logic [1:0]  rect_idx;
  logic [1:0]  rect_last;
  logic        thin;
  coord_t      sel_x, sel_y, sel_w, sel_h;

  // clipper results
  logic              clip_empty;
  logic [COL_W-1:0]  clip_col_first, clip_col_last;
  logic [ROW_W-1:0]  clip_row_first, clip_row_last;

  // byte scan registers
  logic [COL_W-1:0]  col, col_first, col_last;
  logic [PAGE_W-1:0] page, page_first, page_last;
  logic [2:0]        bit_lo, bit_hi;
  logic [ADDR_W-1:0] base;
  logic [ADDR_W-1:0] scan_addr;
  logic [ADDR_W-1:0] clr_addr;
  logic [7:0]        mask;
  logic [2:0]        mask_lo, mask_hi;

  // store port
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata, mem_rdata;
  logic [12:0]       addr_ext;
  logic              addr_ok;

  // control
  logic        rect_done;
  logic        finish;
  logic [7:0]  fin_data;
  logic [2:0]  fin_echo;
  logic        clr_end;

  // Pick the rectangle of the current step.
  always_comb begin
    thin      = (rw < 11'sd2) || (rh < 11'sd2);
    rect_last = ((req == REQ_OUTLINE) && !thin) ? 2'd3 : 2'd0;
    sel_x     = coord_t'(rx);
    sel_y     = coord_t'(ry);
    sel_w     = coord_t'(rw);
    sel_h     = coord_t'(rh);
    if (req == REQ_SET_PIXEL) begin
      sel_w = coord_t'(1);
      sel_h = coord_t'(1);
    end else if (rect_last == 2'd3) begin
      unique case (rect_idx)
        2'd0: sel_h = coord_t'(1);
        2'd1: begin
          sel_y = coord_t'(ry) + coord_t'(rh) - coord_t'(1);
          sel_h = coord_t'(1);
        end
        2'd2: sel_w = coord_t'(1);
        2'd3: begin
          sel_x = coord_t'(rx) + coord_t'(rw) - coord_t'(1);
          sel_w = coord_t'(1);
        end
      endcase
    end
  end

  pfb_clip #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .COL_W         (COL_W),
    .ROW_W         (ROW_W)
  ) u_clip (
    .x         (sel_x),
    .y         (sel_y),
    .w         (sel_w),
    .h         (sel_h),
    .empty     (clip_empty),
    .col_first (clip_col_first),
    .col_last  (clip_col_last),
    .row_first (clip_row_first),
    .row_last  (clip_row_last)
  );

  // Byte mask of the rows covered within the current page.
  always_comb begin
    mask_lo = (page == page_first) ? bit_lo : 3'd0;
    mask_hi = (page == page_last) ? bit_hi : 3'd7;
    for (int i = 0; i < 8; i++) begin
      mask[i] = (3'(i) >= mask_lo) && (3'(i) <= mask_hi);
    end
  end

  assign scan_addr = base + ADDR_W'(col);
  assign addr_ext  = 13'(byte_address);
  assign addr_ok   = addr_ext < 13'(STORE_BYTES);
  assign clr_end   = clr_addr == ADDR_W'(STORE_BYTES - 1);

  // Store access: sweeps write zero, drawing writes back the merged byte.
  always_comb begin
    mem_raddr = (state == ST_IDLE) ? addr_ext[ADDR_W-1:0] : scan_addr;
    mem_we    = (state == ST_WIPE) || (state == ST_CLEAR) || (state == ST_WRITE);
    mem_waddr = ((state == ST_WIPE) || (state == ST_CLEAR)) ? clr_addr : scan_addr;
    if ((state == ST_WIPE) || (state == ST_CLEAR)) begin
      mem_wdata = 8'd0;
    end else if (ron) begin
      mem_wdata = mem_rdata | mask;
    end else begin
      mem_wdata = mem_rdata & ~mask;
    end
  end

  pfb_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_WIPE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and completion.
  always_comb begin
    state_next = state;
    busy       = 1'b1;
    rect_done  = 1'b0;
    finish     = 1'b0;
    fin_data   = 8'd0;
    fin_echo   = req;
    unique case (state)
      ST_WIPE: begin
        if (clr_end) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          priority case (req_type)
            REQ_CLEAR:     state_next = ST_CLEAR;
            REQ_SET_PIXEL,
            REQ_FILL,
            REQ_OUTLINE:   state_next = ST_SETUP;
            REQ_READ_BYTE: state_next = ST_FETCH;
            default: begin
              // unknown code: answer at once, touch nothing
              finish   = 1'b1;
              fin_echo = req_type;
            end
          endcase
        end
      end
      ST_CLEAR: begin
        if (clr_end) begin
          finish     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_SETUP: begin
        if (clip_empty) begin
          rect_done = 1'b1;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        if ((col == col_last) && (page == page_last)) begin
          rect_done = 1'b1;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_FETCH: begin
        finish     = 1'b1;
        fin_data   = rd_ok ? mem_rdata : 8'd0;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    if (rect_done) begin
      if (rect_idx == rect_last) begin
        finish     = 1'b1;
        state_next = ST_IDLE;
      end else begin
        state_next = ST_SETUP;
      end
    end
  end

  // Sweep counter for reset wipe and clear requests.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if ((state == ST_WIPE) || (state == ST_CLEAR)) begin
      clr_addr <= clr_end ? '0 : clr_addr + 1'b1;
    end
  end

  // Result word: one-cycle strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= finish;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      read_data    <= fin_data;
      request_echo <= fin_echo;
    end
  end

  // Latch the request and walk rectangles, pages and columns.
  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && start) begin
      req      <= req_type;
      rx       <= pos_x;
      ry       <= pos_y;
      rw       <= rect_width;
      rh       <= rect_height;
      ron      <= pixel_on;
      rd_ok    <= addr_ok;
      rect_idx <= 2'd0;
    end
    if (rect_done && (rect_idx != rect_last)) begin
      rect_idx <= rect_idx + 2'd1;
    end
    if ((state == ST_SETUP) && !clip_empty) begin
      col        <= clip_col_first;
      col_first  <= clip_col_first;
      col_last   <= clip_col_last;
      page       <= clip_row_first[ROW_W-1:3];
      page_first <= clip_row_first[ROW_W-1:3];
      page_last  <= clip_row_last[ROW_W-1:3];
      bit_lo     <= clip_row_first[2:0];
      bit_hi     <= clip_row_last[2:0];
      base       <= ADDR_W'(int'(clip_row_first[ROW_W-1:3]) * SCREEN_WIDTH);
    end
    if ((state == ST_WRITE) && !rect_done) begin
      if (col != col_last) begin
        col <= col + 1'b1;
      end else begin
        // advance to the next page, back to the left column
        col  <= col_first;
        page <= page + 1'b1;
        base <= base + ADDR_W'(SCREEN_WIDTH);
      end
    end
  end

endmodule

@@ tb/page_framebuffer_checker.sv @@
// Checker for the page framebuffer draw engine: mirrors the frame store and compares result words.
`timescale 1ns / 1ps

module page_framebuffer_checker #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [2:0]         req_type,
  input  logic signed [10:0] pos_x,
  input  logic signed [10:0] pos_y,
  input  logic signed [10:0] rect_width,
  input  logic signed [10:0] rect_height,
  input  logic               pixel_on,
  input  logic [9:0]         byte_address,
  input  logic               done,
  input  logic [7:0]         read_data,
  input  logic [2:0]         request_echo,
  output int                 fail_count,
  output int                 words_pending
);
  import pfb_pkg::*;

  localparam int PAGE_COUNT  = (SCREEN_HEIGHT + 7) / 8;
  localparam int STORE_BYTES = SCREEN_WIDTH * PAGE_COUNT;

  typedef struct {
    logic [7:0] data;
    logic [2:0] echo;
  } result_word_t;

  logic [7:0]   mirror_store [STORE_BYTES];
  result_word_t awaited_words [$];

  function automatic void plot_dot(int x, int y, logic on);
    int idx;
    if (x < 0 || x >= SCREEN_WIDTH || y < 0 || y >= SCREEN_HEIGHT) return;
    idx = (y / 8) * SCREEN_WIDTH + x;
    mirror_store[idx][y % 8] = on;
  endfunction

  function automatic void plot_box(int x, int y, int w, int h, logic on);
    int x0, x1, y0, y1;
    if (w <= 0 || h <= 0) return;
    x0 = (x < 0) ? 0 : x;
    y0 = (y < 0) ? 0 : y;
    x1 = (x + w > SCREEN_WIDTH) ? SCREEN_WIDTH : x + w;
    y1 = (y + h > SCREEN_HEIGHT) ? SCREEN_HEIGHT : y + h;
    for (int r = y0; r < y1; r++)
      for (int c = x0; c < x1; c++)
        plot_dot(c, r, on);
  endfunction

  function automatic void plot_edges(int x, int y, int w, int h, logic on);
    if (w < 2 || h < 2) begin
      plot_box(x, y, w, h, on);
      return;
    end
    plot_box(x, y, w, 1, on);
    plot_box(x, y + h - 1, w, 1, on);
    plot_box(x, y, 1, h, on);
    plot_box(x + w - 1, y, 1, h, on);
  endfunction

  // Apply one request to the mirror and return the word it should produce.
  function automatic result_word_t draw_and_predict(logic [2:0] req, int x, int y, int w, int h,
                                                    logic on, logic [9:0] addr);
    result_word_t word;
    word.data = '0;
    word.echo = req;
    case (req)
      REQ_CLEAR:     foreach (mirror_store[i]) mirror_store[i] = '0;
      REQ_SET_PIXEL: plot_dot(x, y, on);
      REQ_FILL:      plot_box(x, y, w, h, on);
      REQ_OUTLINE:   plot_edges(x, y, w, h, on);
      REQ_READ_BYTE: if (addr < STORE_BYTES) word.data = mirror_store[addr];
      default:       ;
    endcase
    return word;
  endfunction

  always @(posedge clk) begin
    result_word_t want;
    if (rst) begin
      awaited_words.delete();
      foreach (mirror_store[i]) mirror_store[i] = '0;
    end else begin
      // Retire the finished word before queueing the one taken at this edge.
      if (done) begin
        if (awaited_words.size() == 0) begin
          $error("result word with no request outstanding: read_data %0h request_echo %0d",
                 read_data, request_echo);
          fail_count++;
        end else begin
          want = awaited_words.pop_front();
          if (read_data !== want.data) begin
            $error("read_data: expected %0h, actual %0h", want.data, read_data);
            fail_count++;
          end
          if (request_echo !== want.echo) begin
            $error("request_echo: expected %0d, actual %0d", want.echo, request_echo);
            fail_count++;
          end
        end
      end
      if (start && !busy)
        awaited_words.push_back(draw_and_predict(req_type, pos_x, pos_y, rect_width,
                                                 rect_height, pixel_on, byte_address));
    end
    words_pending = awaited_words.size();
  end

endmodule

@@ tb/tb_page_framebuffer_draw_engine_unit.sv @@
// Testbench top for the page framebuffer draw engine: stimulus, timeout and verdict.
`timescale 1ns / 1ps

module tb_page_framebuffer_draw_engine_unit;
  import pfb_pkg::*;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;
  localparam int RANDOM_WORDS  = 1650;
  // Tail of the random part that runs with no sender gaps.
  localparam int STEADY_TAIL   = 150;
  // A full-screen fill is the longest request; even if
  // every word were one, the run would stay several times below this.
  localparam int CYCLE_LIMIT   = 20_000_000;

  logic               clk = 1'b0;
  logic               rst;
  logic               start;
  logic               busy;
  logic [2:0]         req_type;
  logic signed [10:0] pos_x;
  logic signed [10:0] pos_y;
  logic signed [10:0] rect_width;
  logic signed [10:0] rect_height;
  logic               pixel_on;
  logic [9:0]         byte_address;
  logic               done;
  logic [7:0]         read_data;
  logic [2:0]         request_echo;

  int fail_count;
  int words_pending;
  int cycle_count = 0;

  always #6 clk = ~clk;

  page_framebuffer_draw_engine_unit #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) dut (
    .clk, .rst, .start, .busy, .req_type, .pos_x, .pos_y, .rect_width, .rect_height,
    .pixel_on, .byte_address, .done, .read_data, .request_echo
  );

  page_framebuffer_checker #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) checker_i (
    .clk, .rst, .start, .busy, .req_type, .pos_x, .pos_y, .rect_width, .rect_height,
    .pixel_on, .byte_address, .done, .read_data, .request_echo,
    .fail_count, .words_pending
  );

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Present one request word at the falling edge and hold it until the
  // engine takes it (start high and busy low at a rising edge). Leave start
  // high so that back-to-back words need no second assignment.
  task automatic send_word(input logic [2:0] req, input int x, input int y, input int w,
                           input int h, input logic on, input int addr);
    start        <= 1'b1;
    req_type     <= req;
    pos_x        <= 11'(x);
    pos_y        <= 11'(y);
    rect_width   <= 11'(w);
    rect_height  <= 11'(h);
    pixel_on     <= on;
    byte_address <= 10'(addr);
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Drop start for a burst of idle cycles.
  task automatic idle_burst();
    start <= 1'b0;
    repeat ($urandom_range(1, 9)) @(negedge clk);
  endtask

  // Mostly near the screen, sometimes anywhere in the 11-bit range.
  function automatic int pick_coord(int span);
    int raw;
    raw = $urandom();
    if ($urandom_range(0, 9) == 0) return int'($signed(raw[10:0]));
    return $urandom_range(0, span + 15) - 8;
  endfunction

  // Mostly small sizes including empty ones; rarely the full 11-bit range.
  function automatic int pick_size();
    int raw;
    int roll;
    raw  = $urandom();
    roll = $urandom_range(0, 99);
    if (roll < 3) return int'($signed(raw[10:0]));
    if (roll < 10) return 1;
    return $urandom_range(0, 22) - 2;
  endfunction

  initial begin
    int        x, y, w, h, roll, counted, hit_x, hit_y, target;
    logic [2:0] req;
    bit        gaps_on;

    rst          = 1'b1;
    start        = 1'b0;
    req_type     = REQ_CLEAR;
    pos_x        = '0;
    pos_y        = '0;
    rect_width   = '0;
    rect_height  = '0;
    pixel_on     = 1'b0;
    byte_address = '0;

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Directed part: corners, clipping, empty and thin rectangles, unknown
    // codes, and a clear. The engine is busy sweeping the store at first.
    send_word(REQ_READ_BYTE, 5, 5, 5, 5, 1'b1, 0);
    send_word(REQ_READ_BYTE, 0, 0, 0, 0, 1'b0, 1023);
    send_word(REQ_SET_PIXEL, 0, 0, 3, 3, 1'b1, 77);
    send_word(REQ_SET_PIXEL, SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1, 0, 0, 1'b1, 0);
    send_word(REQ_READ_BYTE, 0, 0, 0, 0, 1'b0, 0);
    send_word(REQ_READ_BYTE, 0, 0, 0, 0, 1'b0, 1023);
    send_word(REQ_SET_PIXEL, -1, 5, 0, 0, 1'b1, 0);
    send_word(REQ_SET_PIXEL, SCREEN_WIDTH, 0, 0, 0, 1'b1, 0);
    send_word(REQ_SET_PIXEL, 0, SCREEN_HEIGHT, 0, 0, 1'b1, 0);
    send_word(REQ_SET_PIXEL, -1024, -1024, 1023, 1023, 1'b1, 1023);
    send_word(REQ_SET_PIXEL, 1023, 1023, -1024, -1024, 1'b1, 0);
    send_word(REQ_FILL, -5, -3, 10, 12, 1'b1, 0);
    send_word(REQ_READ_BYTE, 0, 0, 0, 0, 1'b0, 0);
    send_word(REQ_READ_BYTE, 0, 0, 0, 0, 1'b0, SCREEN_WIDTH);
    send_word(REQ_FILL, 0, 0, 0, 20, 1'b0, 0);
    send_word(REQ_FILL, 0, 0, 20, -1024, 1'b0, 0);
    send_word(REQ_OUTLINE, 40, 0, 1, 10, 1'b1, 0);
    send_word(REQ_OUTLINE, 20, 10, 10, 10, 1'b1, 0);
    send_word(REQ_READ_BYTE, 0, 0, 0, 0, 1'b0, SCREEN_WIDTH + 20);
    send_word(REQ_READ_BYTE, 0, 0, 0, 0, 1'b0, SCREEN_WIDTH + 25);
    send_word(REQ_OUTLINE, -1024, -1024, 1023, 1023, 1'b1, 0);
    send_word(REQ_OUTLINE, -1, -1, 1023, 1023, 1'b0, 0);
    send_word(REQ_FILL, 0, 0, 1023, 1023, 1'b0, 0);
    send_word(3'd5, 1, 2, 3, 4, 1'b1, 5);
    send_word(3'd6, -1, -2, -3, -4, 1'b0, 6);
    send_word(3'd7, 1023, 1023, 1023, 1023, 1'b1, 1023);
    send_word(REQ_SET_PIXEL, 3, 9, 0, 0, 1'b1, 0);
    send_word(REQ_CLEAR, 3, 9, 1, 1, 1'b1, 131);
    send_word(REQ_READ_BYTE, 0, 0, 0, 0, 1'b0, SCREEN_WIDTH + 3);

    // Random part: drawing mixed with reads that mostly land on what was
    // just drawn, so that the mirror is actually exercised.
    counted = 0;
    hit_x   = 0;
    hit_y   = 0;
    gaps_on = 1'b1;
    while (counted < RANDOM_WORDS) begin
      x    = pick_coord(SCREEN_WIDTH);
      y    = pick_coord(SCREEN_HEIGHT);
      w    = pick_size();
      h    = pick_size();
      roll = $urandom_range(0, 99);
      if (roll < 2)       req = REQ_CLEAR;
      else if (roll < 32) req = REQ_SET_PIXEL;
      else if (roll < 47) req = REQ_FILL;
      else if (roll < 57) req = REQ_OUTLINE;
      else if (roll < 97) req = REQ_READ_BYTE;
      else                req = 3'($urandom_range(5, 7));

      // Remember a point inside the latest drawing for targeted reads.
      if (req == REQ_SET_PIXEL) begin
        hit_x = x;
        hit_y = y;
      end else if (req == REQ_FILL || req == REQ_OUTLINE) begin
        hit_x = x + ((w > 0) ? $urandom_range(0, (w > 32) ? 32 : w - 1) : 0);
        hit_y = y + ((h > 0) ? $urandom_range(0, (h > 32) ? 32 : h - 1) : 0);
      end

      if (hit_x >= 0 && hit_x < SCREEN_WIDTH && hit_y >= 0 && hit_y < SCREEN_HEIGHT &&
          $urandom_range(0, 1) == 1)
        target = (hit_y / 8) * SCREEN_WIDTH + hit_x;
      else
        target = $urandom_range(0, 1023);

      send_word(req, x, y, w, h, 1'($urandom()), target);
      if (req <= REQ_READ_BYTE) counted++;

      // Toggle between gappy and gap-free stretches; hold the tail steady.
      if ($urandom_range(0, 39) == 0) gaps_on = !gaps_on;
      if (gaps_on && counted < RANDOM_WORDS - STEADY_TAIL && $urandom_range(0, 2) == 0)
        idle_burst();
    end
    start <= 1'b0;

    // Drain every outstanding word, then let the engine settle.
    while (words_pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

@@ page_framebuffer_draw_engine_unit.f @@
design/pfb_pkg.sv
design/pfb_ram.sv
design/pfb_clip.sv
design/page_framebuffer_draw_engine_unit.sv
tb/page_framebuffer_checker.sv
tb/tb_page_framebuffer_draw_engine_unit.sv
